FILE: hw/rtl/khm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khm_pkg
// Shared types and constants for the k-way merge min-heap: operation codes,
// sequencer states, child pick result and default sizes.
// ----------------------------------------------------------------------------
package khm_pkg;

	localparam int DEF_MAX_LISTS   = 16;
	localparam int DEF_VALUE_WIDTH = 32;
	localparam int LIST_W          = 4;
	localparam int PORT_VALUE_W    = 32;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_BUILD   = 2'd1,
		OP_REPLACE = 2'd2,
		OP_REMOVE  = 2'd3
	} khm_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROOT,
		ST_POP,
		ST_BLD_RD,
		ST_BLD_LD,
		ST_SIFT_RD,
		ST_SIFT_CMP,
		ST_FIN_RD,
		ST_FIN
	} khm_state_t;

	// which child, if any, moves up into the current position
	typedef struct packed {
		logic to_left;
		logic to_right;
	} khm_pick_t;

endpackage
`default_nettype wire

FILE: hw/rtl/khm_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khm_mem
// Heap entry storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module khm_mem #(
	parameter int W     = 36,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr_a,
	input  wire logic [AW-1:0] raddr_b,
	output logic      [W-1:0]  rdata_a,
	output logic      [W-1:0]  rdata_b
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/khm_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khm_pick
// Compare unit shared by every sift-down level: decides whether the held
// entry stays or the left or right child moves up.
// ----------------------------------------------------------------------------
module khm_pick
	import khm_pkg::*;
#(
	parameter int VW = DEF_VALUE_WIDTH
) (
	input  wire logic signed [VW-1:0] held_val,
	input  wire logic signed [VW-1:0] left_val,
	input  wire logic signed [VW-1:0] right_val,
	input  wire logic                 has_right,
	output khm_pick_t                 pick
);

	logic                 held_lt_left;
	logic                 left_lt_held;
	logic signed [VW-1:0] best_val;
	logic                 right_lt_best;

	always_comb begin
		held_lt_left  = held_val < left_val;
		left_lt_held  = left_val < held_val;
		// with two children an equal left child beats the parent
		best_val      = held_lt_left ? held_val : left_val;
		right_lt_best = right_val < best_val;
		pick          = '0;
		if (has_right) begin
			pick.to_right = right_lt_best;
			pick.to_left  = !right_lt_best && !held_lt_left;
		end else begin
			pick.to_left  = left_lt_held;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/k_way_merge_min_heap_top.sv
// Operation time is set by the sift-down loop over the shared compare unit and the
// two-read, one-write entry memory: a load does not sift, build sifts down from each
// start node and replace or remove from the root, with compare steps until the entry
// comes to rest, at a leaf or above.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset clears the heap size and control; entry storage is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_merge_min_heap_top
// Min-heap of (value, list) pairs driving a k-way merge: load, build,
// replace root and remove root, with a sequencer around one compare unit.
// ----------------------------------------------------------------------------
module k_way_merge_min_heap_top
	import khm_pkg::*;
#(
	parameter int MAX_LISTS   = DEF_MAX_LISTS,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	parameter int CW          = $clog2(MAX_LISTS + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     opcode,
	input  wire logic signed [PORT_VALUE_W-1:0] item_value,
	input  wire logic [LIST_W-1:0]              item_list,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                popped_valid,
	output logic signed [PORT_VALUE_W-1:0]      popped_value,
	output logic [LIST_W-1:0]                   popped_list,
	output logic [LIST_W-1:0]                   root_list,
	output logic [CW-1:0]                       entries_left,
	output logic                                error
);

	localparam int AW = $clog2(MAX_LISTS);
	localparam int EW = VALUE_WIDTH + LIST_W;

	khm_state_t state_q, state_d;

	logic [CW-1:0]                 size_q;
	logic [AW-1:0]                 pos_q;
	logic [AW-1:0]                 idx_q;
	logic                          bld_q;
	logic signed [VALUE_WIDTH-1:0] held_val_q;
	logic [LIST_W-1:0]             held_src_q;
	logic signed [VALUE_WIDTH-1:0] new_val_q;
	logic                          op_rem_q;
	logic                          res_pv_q;
	logic signed [VALUE_WIDTH-1:0] res_pval_q;
	logic [LIST_W-1:0]             res_plist_q;
	logic                          res_err_q;

	logic                          out_valid_q;
	logic                          out_pv_q;
	logic signed [VALUE_WIDTH-1:0] out_pval_q;
	logic [LIST_W-1:0]             out_plist_q;
	logic [LIST_W-1:0]             out_root_q;
	logic [CW-1:0]                 out_size_q;
	logic                          out_err_q;

	logic                          accept;
	logic                          heap_full;
	logic                          heap_empty;
	logic signed [VALUE_WIDTH-1:0] val_in;
	logic [CW:0]                   child_l;
	logic [CW:0]                   child_r;
	logic [CW:0]                   n_ext;
	logic                          has_l;
	logic                          has_r;
	logic                          out_free;
	logic                          sift_end;

	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [EW-1:0]                 mem_wdata;
	logic [AW-1:0]                 mem_raddr_a;
	logic [AW-1:0]                 mem_raddr_b;
	logic [EW-1:0]                 mem_rdata_a;
	logic [EW-1:0]                 mem_rdata_b;
	logic signed [VALUE_WIDTH-1:0] rd_a_val;
	logic signed [VALUE_WIDTH-1:0] rd_b_val;
	logic [LIST_W-1:0]             rd_a_src;
	logic [LIST_W-1:0]             rd_b_src;
	khm_pick_t                     pick;

	khm_mem #(
		.W     (EW),
		.DEPTH (MAX_LISTS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	khm_pick #(
		.VW (VALUE_WIDTH)
	) u_pick (
		.held_val  (held_val_q),
		.left_val  (rd_a_val),
		.right_val (rd_b_val),
		.has_right (has_r),
		.pick      (pick)
	);

	assign rd_a_val = mem_rdata_a[VALUE_WIDTH-1:0];
	assign rd_b_val = mem_rdata_b[VALUE_WIDTH-1:0];
	assign rd_a_src = mem_rdata_a[EW-1:VALUE_WIDTH];
	assign rd_b_src = mem_rdata_b[EW-1:VALUE_WIDTH];

	assign val_in     = VALUE_WIDTH'(item_value);
	assign heap_full  = size_q == CW'(MAX_LISTS);
	assign heap_empty = size_q == '0;
	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;

	assign child_l = (CW + 1)'({pos_q, 1'b1});
	assign child_r = child_l + (CW + 1)'(1);
	assign n_ext   = {1'b0, size_q};
	assign has_l   = child_l < n_ext;
	assign has_r   = child_r < n_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = state_q != ST_IDLE;
		mem_we      = 1'b0;
		mem_waddr   = pos_q;
		mem_wdata   = {held_src_q, held_val_q};
		mem_raddr_a = '0;
		mem_raddr_b = '0;
		sift_end    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (khm_op_t'(opcode))
						OP_LOAD: begin
							if (!heap_full) begin
								mem_we    = 1'b1;
								mem_waddr = AW'(size_q);
								mem_wdata = {item_list, val_in};
							end
							state_d = ST_FIN_RD;
						end
						OP_BUILD: begin
							state_d = (size_q > CW'(1)) ? ST_BLD_RD : ST_FIN_RD;
						end
						OP_REPLACE, OP_REMOVE: begin
							state_d = heap_empty ? ST_FIN_RD : ST_ROOT;
						end
						default: state_d = ST_FIN_RD;
					endcase
				end
			end
			ST_ROOT: begin
				mem_raddr_a = '0;
				mem_raddr_b = AW'(size_q - CW'(1));
				state_d     = ST_POP;
			end
			ST_POP: begin
				state_d = ST_SIFT_RD;
			end
			ST_BLD_RD: begin
				mem_raddr_a = idx_q;
				state_d     = ST_BLD_LD;
			end
			ST_BLD_LD: begin
				state_d = ST_SIFT_RD;
			end
			ST_SIFT_RD: begin
				mem_raddr_a = child_l[AW-1:0];
				mem_raddr_b = child_r[AW-1:0];
				if (has_l) begin
					state_d = ST_SIFT_CMP;
				end else begin
					mem_we   = 1'b1;
					sift_end = 1'b1;
				end
			end
			ST_SIFT_CMP: begin
				mem_we = 1'b1;
				if (pick.to_right) begin
					mem_wdata = mem_rdata_b;
					state_d   = ST_SIFT_RD;
				end else if (pick.to_left) begin
					mem_wdata = mem_rdata_a;
					state_d   = ST_SIFT_RD;
				end else begin
					sift_end = 1'b1;
				end
			end
			ST_FIN_RD: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// held entry placed: next build node or wrap up
		if (sift_end) begin
			state_d = (bld_q && idx_q != '0) ? ST_BLD_RD : ST_FIN_RD;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			bld_q       <= 1'b0;
			op_rem_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && accept) begin
				bld_q    <= khm_op_t'(opcode) == OP_BUILD;
				op_rem_q <= khm_op_t'(opcode) == OP_REMOVE;
				idx_q    <= AW'((size_q >> 1) - CW'(1));
				if (khm_op_t'(opcode) == OP_LOAD && !heap_full) begin
					size_q <= size_q + CW'(1);
				end
			end
			if (state_q == ST_POP) begin
				pos_q <= '0;
				if (op_rem_q) begin
					size_q <= size_q - CW'(1);
				end
			end
			if (state_q == ST_BLD_LD) begin
				pos_q <= idx_q;
			end
			if (state_q == ST_SIFT_CMP) begin
				if (pick.to_right) begin
					pos_q <= child_r[AW-1:0];
				end else if (pick.to_left) begin
					pos_q <= child_l[AW-1:0];
				end
			end
			if (sift_end && bld_q && idx_q != '0) begin
				idx_q <= idx_q - AW'(1);
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			new_val_q   <= val_in;
			res_pv_q    <= 1'b0;
			res_pval_q  <= '0;
			res_plist_q <= '0;
			res_err_q   <= (khm_op_t'(opcode) == OP_LOAD && heap_full) ||
				((khm_op_t'(opcode) == OP_REPLACE || khm_op_t'(opcode) == OP_REMOVE) &&
				heap_empty);
		end
		if (state_q == ST_POP) begin
			res_pv_q    <= 1'b1;
			res_pval_q  <= rd_a_val;
			res_plist_q <= rd_a_src;
			if (op_rem_q) begin
				held_val_q <= rd_b_val;
				held_src_q <= rd_b_src;
			end else begin
				held_val_q <= new_val_q;
				held_src_q <= rd_a_src;
			end
		end
		if (state_q == ST_BLD_LD) begin
			held_val_q <= rd_a_val;
			held_src_q <= rd_a_src;
		end
		if (state_q == ST_FIN && out_free) begin
			out_pv_q    <= res_pv_q;
			out_pval_q  <= res_pval_q;
			out_plist_q <= res_plist_q;
			out_root_q  <= heap_empty ? '0 : rd_a_src;
			out_size_q  <= size_q;
			out_err_q   <= res_err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_valid = out_pv_q;
	assign popped_value = PORT_VALUE_W'(out_pval_q);
	assign popped_list  = out_plist_q;
	assign root_list    = out_root_q;
	assign entries_left = out_size_q;
	assign error        = out_err_q;

`ifndef SYNTHESIS
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= CW'(MAX_LISTS))
		else $error("heap size above capacity");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside wrap-up state");

	a_cmp_has_child: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SIFT_CMP |-> has_l)
		else $error("compare step without a left child");

	a_err_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> !out_pv_q)
		else $error("error result carries a popped value");

	a_idle_write_load: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q == ST_IDLE |-> accept && opcode == OP_LOAD && !heap_full)
		else $error("entry write in idle without a load transfer");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the k-way merge min-heap. A local heap predictor
// tracks every accepted transfer and the checker compares each result, field
// by field, against the oldest prediction. Stimulus is a directed pass over
// the corner cases followed by randomized merge sessions mixed with noise,
// under three idling mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import khm_pkg::*;

	localparam int HEAP_DEPTH = DEF_MAX_LISTS;

	typedef struct packed {
		logic        pv;
		logic [31:0] pval;
		logic [3:0]  plist;
		logic [3:0]  rlist;
		logic [4:0]  left;
		logic        err;
	} pop_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [1:0]  opcode = 2'd0;
	logic [31:0] item_value = 32'd0;
	logic [3:0]  item_list = 4'd0;
	logic        out_stall = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire         popped_valid;
	wire [31:0]  popped_value;
	wire [3:0]   popped_list;
	wire [3:0]   root_list;
	wire [4:0]   entries_left;
	wire         error;

	// predictor state
	logic signed [31:0] heap_val [HEAP_DEPTH];
	logic [3:0]         heap_src [HEAP_DEPTH];
	int                 heap_cnt = 0;

	pop_result_t pending_pops [$];
	int items_accepted = 0;
	int miscompares = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	// per-list feed for the merge sessions
	longint list_next [16];
	int     list_left [16];

	k_way_merge_min_heap_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.item_value   (item_value),
		.item_list    (item_list),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_valid (popped_valid),
		.popped_value (popped_value),
		.popped_list  (popped_list),
		.root_list    (root_list),
		.entries_left (entries_left),
		.error        (error)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void sift_from(int start);
		int pos;
		int lc;
		int rc;
		int pick;
		bit done;
		logic signed [31:0] tv;
		logic [3:0] ts;
		pos = start;
		done = 1'b0;
		while (!done) begin
			lc = 2 * pos + 1;
			rc = lc + 1;
			pick = pos;
			if (rc < heap_cnt) begin
				// parent equal to left child still moves the left child up
				pick = (heap_val[pos] < heap_val[lc]) ? pos : lc;
				if (heap_val[rc] < heap_val[pick])
					pick = rc;
			end else if (lc < heap_cnt) begin
				pick = (heap_val[lc] < heap_val[pos]) ? lc : pos;
			end
			if (pick == pos) begin
				done = 1'b1;
			end else begin
				tv = heap_val[pos];
				ts = heap_src[pos];
				heap_val[pos] = heap_val[pick];
				heap_src[pos] = heap_src[pick];
				heap_val[pick] = tv;
				heap_src[pick] = ts;
				pos = pick;
			end
		end
	endfunction

	function automatic pop_result_t merge_heap_apply(khm_op_t op, logic [31:0] v,
			logic [3:0] lst);
		pop_result_t r;
		r = '0;
		case (op)
			OP_LOAD: begin
				if (heap_cnt >= HEAP_DEPTH) begin
					r.err = 1'b1;
				end else begin
					heap_val[heap_cnt] = $signed(v);
					heap_src[heap_cnt] = lst;
					heap_cnt++;
				end
			end
			OP_BUILD: begin
				for (int i = heap_cnt / 2 - 1; i >= 0; i--)
					sift_from(i);
			end
			default: begin
				if (heap_cnt == 0) begin
					r.err = 1'b1;
				end else begin
					r.pv = 1'b1;
					r.pval = heap_val[0];
					r.plist = heap_src[0];
					if (op == OP_REPLACE) begin
						heap_val[0] = $signed(v);
					end else begin
						heap_val[0] = heap_val[heap_cnt - 1];
						heap_src[0] = heap_src[heap_cnt - 1];
						heap_cnt--;
					end
					sift_from(0);
				end
			end
		endcase
		r.rlist = (heap_cnt > 0) ? heap_src[0] : 4'd0;
		r.left = 5'(heap_cnt);
		return r;
	endfunction

	task automatic send_item(input khm_op_t op, input logic [31:0] v, input logic [3:0] lst);
		pop_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		item_value = v;
		item_list = lst;
		do
			@(posedge clk);
		while (in_stall);
		r = merge_heap_apply(op, v, lst);
		pending_pops.push_back(r);
		items_accepted++;
	endtask

	task automatic flag_mismatch(input string what, input pop_result_t e, input pop_result_t a);
		miscompares++;
		if (miscompares <= 10) begin
			$display("mismatch (%s): expected pv=%0d val=%0d plist=%0d root=%0d left=%0d err=%0d",
				what, e.pv, $signed(e.pval), e.plist, e.rlist, e.left, e.err);
			$display("    got pv=%0d val=%0d plist=%0d root=%0d left=%0d err=%0d",
				a.pv, $signed(a.pval), a.plist, a.rlist, a.left, a.err);
		end
	endtask

	// receiver: random stall, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall = 1'b1;
			hold_cycles--;
		end else begin
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pop_result_t got;
		pop_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {popped_valid, popped_value, popped_list, root_list, entries_left, error};
			if (pending_pops.size() == 0) begin
				flag_mismatch("no transfer expected", '0, got);
			end else begin
				want = pending_pops.pop_front();
				if (got.pv !== want.pv || got.pval !== want.pval ||
						got.plist !== want.plist || got.rlist !== want.rlist ||
						got.left !== want.left || got.err !== want.err)
					flag_mismatch("field", want, got);
			end
		end
	end

	task automatic test_directed();
		logic [31:0] vals [14];
		vals = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd7, 32'd7, 32'd7, 32'd7,
			32'h8000_0000, 32'h7FFF_FFFF, -32'sd5, 32'd100, -32'sd100,
			32'h5555_5555, 32'hAAAA_AAAA};
		// pops and build on an empty heap
		send_item(OP_REMOVE, 32'd9, 4'd3);
		send_item(OP_REPLACE, 32'd9, 4'd3);
		send_item(OP_BUILD, 32'd0, 4'd0);
		// single entry
		send_item(OP_LOAD, 32'h7FFF_FFFF, 4'd15);
		send_item(OP_BUILD, 32'hFFFF_FFFF, 4'd15);
		send_item(OP_REPLACE, 32'h8000_0000, 4'd0);
		// fill without ordering, then replace on the unbuilt array
		for (int i = 0; i < 14; i++)
			send_item(OP_LOAD, vals[i], 4'(i));
		send_item(OP_REPLACE, 32'd7, 4'd9);
		send_item(OP_LOAD, 32'd7, 4'd14);
		// load into a full heap
		send_item(OP_LOAD, 32'd3, 4'd5);
		send_item(OP_BUILD, 32'd0, 4'd0);
		send_item(OP_REMOVE, 32'hFFFF_FFFF, 4'd15);
		send_item(OP_REPLACE, 32'h7FFF_FFFF, 4'd10);
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 20; i++)
			send_item((i % 2) ? OP_REMOVE : OP_LOAD, $urandom, 4'($urandom_range(15)));
	endtask

	task automatic test_random_merge(input int budget);
		int stop_at;
		int k;
		int id;
		int j;
		int tmp;
		int base32;
		int perm [16];
		logic [3:0] src;
		bit tie_heavy;
		stop_at = items_accepted + budget;
		for (int i = 0; i < 16; i++)
			perm[i] = i;
		while (items_accepted < stop_at) begin
			// noise: any opcode, any value
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 6))
					send_item(khm_op_t'($urandom_range(3)), $urandom,
						4'($urandom_range(15)));
			while (heap_cnt > 0)
				send_item(OP_REMOVE, $urandom, 4'($urandom_range(15)));
			k = ($urandom_range(9) == 0) ? 16 : $urandom_range(1, 5);
			for (int i = 15; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = perm[i];
				perm[i] = perm[j];
				perm[j] = tmp;
			end
			tie_heavy = ($urandom_range(2) == 0);
			for (int i = 0; i < k; i++) begin
				id = perm[i];
				base32 = $urandom;
				base32 = tie_heavy ? (base32 >>> 28) : (base32 >>> $urandom_range(0, 31));
				send_item(OP_LOAD, base32, 4'(id));
				list_next[id] = longint'(base32) +
					(tie_heavy ? $urandom_range(0, 2) : $urandom_range(0, 1 << 20));
				list_left[id] = $urandom_range(0, 6);
			end
			// now and then the build is left out
			if ($urandom_range(7) != 0)
				send_item(OP_BUILD, $urandom, 4'($urandom_range(15)));
			while (heap_cnt > 0) begin
				src = heap_src[0];
				if ($urandom_range(29) == 0) begin
					send_item(OP_REPLACE, $urandom, 4'($urandom_range(15)));
				end else if (list_left[src] > 0 && list_next[src] <= 64'sd2147483647) begin
					send_item(OP_REPLACE, list_next[src][31:0], 4'($urandom_range(15)));
					list_next[src] += tie_heavy ? $urandom_range(0, 2) :
						$urandom_range(0, 1 << 20);
					list_left[src]--;
				end else begin
					send_item(OP_REMOVE, $urandom, 4'($urandom_range(15)));
				end
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 10;
		recv_stall_pct = 48;
		test_directed();
		test_backpressure();
		test_random_merge(450);

		send_idle_pct = 48;
		recv_stall_pct = 10;
		test_random_merge(480);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_merge(480);

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_pops.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (miscompares == 0 && pending_pops.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
